// ===== src/abgs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// abgs_pkg
// Types and constants of the adaptive background subtractor: field widths,
// register codes, frame history codes, arithmetic constants and the packed
// layouts of a frame memory word and of a result item.
// ============================================================================
package abgs_pkg;

   localparam int PIX_W       = 8;
   localparam int CFG_W       = 18;
   localparam int FRAME_W     = 18;
   localparam int ALPHA_W     = 16;
   localparam int GAIN_W      = 16;
   localparam int GB_W        = ALPHA_W + GAIN_W;
   localparam int MUL_W       = ALPHA_W + PIX_W;
   localparam int PROD_W      = GB_W + PIX_W;
   localparam int ACC_W       = PROD_W + 1;
   localparam int TH_FRAC     = 23;
   localparam int BG_FRAC     = 15;

   localparam logic [FRAME_W-1:0] FRAME_PIXELS_RESET = FRAME_W'(76800);
   localparam logic [ALPHA_W-1:0] BLEND_ALPHA_RESET  = ALPHA_W'(30147);
   localparam logic [GAIN_W-1:0]  SPREAD_GAIN_RESET  = GAIN_W'(768);

   localparam logic [ALPHA_W-1:0] ALPHA_ONE    = ALPHA_W'(32768);
   localparam logic [PIX_W-1:0]   MIN_THRESH   = PIX_W'(20);
   localparam logic [PIX_W-1:0]   START_THRESH = PIX_W'(127);
   localparam logic [PIX_W-1:0]   PIX_MAX      = PIX_W'(255);
   localparam logic [MUL_W-1:0]   BG_ROUND     = MUL_W'(16384);

   localparam logic CMD_PIXEL   = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = 3;

   typedef enum logic [1:0] {
      CSR_FRAME_PIXELS = 2'd0,
      CSR_BLEND_ALPHA  = 2'd1,
      CSR_SPREAD_GAIN  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      SEEN_NONE  = 2'd0,
      SEEN_ONE   = 2'd1,
      SEEN_START = 2'd2,
      SEEN_FULL  = 2'd3
   } seen_type;

   typedef struct packed {
      logic [PIX_W-1:0] prev;
      logic [PIX_W-1:0] older;
      logic [PIX_W-1:0] bg;
      logic [PIX_W-1:0] th;
   } mem_word_type;

   typedef struct packed {
      logic             valid_res;
      logic [PIX_W-1:0] background_out;
      logic             moving;
      logic [PIX_W-1:0] threshold_out;
      logic             end_of_frame;
   } rsp_item_type;

   function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] x,
                                                input logic [PIX_W-1:0] y);
      return (x > y) ? (x - y) : (y - x);
   endfunction

endpackage
`default_nettype wire

// ===== src/adaptive_background_subtractor_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// adaptive_background_subtractor_top
// Three-frame difference background subtraction with a per-pixel adaptive
// threshold. Frame history, background and threshold live in one frame
// memory that every pixel reads, updates and writes back.
// ============================================================================
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  req_cmd, req_pixel
//  rsp      out        rsp_valid/rsp_ready  rsp_valid_res, rsp_background_out,
//                                           rsp_moving, rsp_threshold_out,
//                                           rsp_end_of_frame
//  csr      in         csr_we               csr_index, csr_wdata
//
//  One item per cycle unless credit runs out or a hazard stalls req_ready; an
//  accepted item passes stages 1 to 4 into the result queue, which raises
//  rsp_valid. An item whose pixel entry is still in flight in the 4-stage
//  read-modify-write pipeline waits until the write-back is done, so a frame of N < 5 pixels stalls on it.
//  An 8-entry result queue with a credit count absorbs rsp stalls; req_ready
//  does not depend on rsp_ready. Reset is synchronous and needs no clearing.
//
module adaptive_background_subtractor_top
   import abgs_pkg::*;
#(
   parameter int MAX_PIXELS = 131072
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire                     req_cmd,
   input  wire  [PIX_W-1:0]        req_pixel,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output logic                    rsp_valid_res,
   output logic [PIX_W-1:0]        rsp_background_out,
   output logic                    rsp_moving,
   output logic [PIX_W-1:0]        rsp_threshold_out,
   output logic                    rsp_end_of_frame,
   input  wire                     csr_we,
   input  wire  [1:0]              csr_index,
   input  wire  [CFG_W-1:0]        csr_wdata
);

   localparam int IDX_W = $clog2(MAX_PIXELS);
   localparam int CNT_W = IDX_W + 1;
   localparam int SZ_W  = ((CNT_W > FRAME_W) ? CNT_W : FRAME_W) + 1;
   localparam int RQ_W  = RSP_PTR_W + 1;

   // configuration
   logic [FRAME_W-1:0] frame_pixels_ff;
   logic [ALPHA_W-1:0] blend_alpha_ff;
   logic [GAIN_W-1:0]  spread_gain_ff;
   logic [ALPHA_W-1:0] alpha_a;
   logic [ALPHA_W-1:0] alpha_b;
   logic [GB_W-1:0]    gb_ff;

   // sequencing
   logic [IDX_W-1:0]   pixel_index_ff;
   logic [IDX_W-1:0]   pixel_index_in;
   seen_type           frames_seen_ff;
   seen_type           frames_seen_in;
   logic [SZ_W-1:0]    size_eff;
   logic [SZ_W-1:0]    idx_next;
   logic               eof_cur;
   logic               hazard;
   logic               req_acc;

   // frame memory
   mem_word_type       frame_mem [MAX_PIXELS];
   mem_word_type       rd_word_ff;
   mem_word_type       wr_word;
   logic               wr_en;

   // stage 1
   logic               s1_v_ff, s1_rst_ff, s1_eof_ff;
   logic [IDX_W-1:0]   s1_idx_ff;
   logic [PIX_W-1:0]   s1_pix_ff;
   seen_type           s1_mode_ff;
   logic [PIX_W-1:0]   s1_bg_old, s1_th_old;
   logic               s1_mov;
   logic [MUL_W-1:0]   s2_pa_bg_in, s2_pb_pix_in, s2_pa_th_in;

   // stage 2
   logic               s2_v_ff, s2_rst_ff, s2_eof_ff, s2_mov_ff;
   logic [IDX_W-1:0]   s2_idx_ff;
   logic [PIX_W-1:0]   s2_pix_ff, s2_prev_ff, s2_bg_old_ff, s2_th_old_ff;
   seen_type           s2_mode_ff;
   logic [MUL_W-1:0]   s2_pa_bg_ff, s2_pb_pix_ff, s2_pa_th_ff;
   logic [MUL_W-1:0]   s2_bg_sum;
   logic [PIX_W:0]     s2_bg_q;
   logic [PIX_W-1:0]   s2_bg_blend;
   logic [PIX_W-1:0]   s3_bg_new_in, s3_diff_in;

   // stage 3
   logic               s3_v_ff, s3_rst_ff, s3_eof_ff, s3_mov_ff;
   logic [IDX_W-1:0]   s3_idx_ff;
   logic [PIX_W-1:0]   s3_pix_ff, s3_prev_ff, s3_bg_old_ff, s3_th_old_ff;
   logic [PIX_W-1:0]   s3_bg_new_ff, s3_diff_ff;
   seen_type           s3_mode_ff;
   logic [MUL_W-1:0]   s3_pa_th_ff;
   logic [PROD_W-1:0]  s4_prod_in;

   // stage 4
   logic               s4_v_ff, s4_rst_ff, s4_eof_ff, s4_mov_ff;
   logic [IDX_W-1:0]   s4_idx_ff;
   logic [PIX_W-1:0]   s4_pix_ff, s4_prev_ff, s4_bg_old_ff, s4_th_old_ff;
   logic [PIX_W-1:0]   s4_bg_new_ff;
   seen_type           s4_mode_ff;
   logic [MUL_W-1:0]   s4_pa_th_ff;
   logic [PROD_W-1:0]  s4_prod_ff;
   logic [ACC_W-1:0]   s4_acc, s4_rnd;
   logic [ACC_W-TH_FRAC-1:0] s4_rnd_q;
   logic [PIX_W-1:0]   s4_th_blend, s4_th_upd, s4_th_new;
   logic               s4_processed;
   rsp_item_type       s4_item;

   // result queue
   rsp_item_type       rsp_fifo [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RQ_W-1:0]    count_ff, count_in;
   logic [RQ_W-1:0]    credit_ff, credit_in;
   logic               rsp_pop;
   rsp_item_type       rsp_head;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_pixels_ff <= FRAME_PIXELS_RESET;
         blend_alpha_ff  <= BLEND_ALPHA_RESET;
         spread_gain_ff  <= SPREAD_GAIN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAME_PIXELS: frame_pixels_ff <= csr_wdata[FRAME_W-1:0];
            CSR_BLEND_ALPHA:  blend_alpha_ff  <= csr_wdata[ALPHA_W-1:0];
            CSR_SPREAD_GAIN:  spread_gain_ff  <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   assign alpha_a = (blend_alpha_ff > ALPHA_ONE) ? ALPHA_ONE : blend_alpha_ff;
   assign alpha_b = ALPHA_ONE - alpha_a;

   always_ff @(posedge clock) begin
      gb_ff <= GB_W'(alpha_b) * GB_W'(spread_gain_ff);
   end

   // ------------------------------------------------------------ sequencing
   always_comb begin
      size_eff = SZ_W'(frame_pixels_ff);
      if (size_eff == '0) begin
         size_eff = SZ_W'(1);
      end else if (size_eff > SZ_W'(MAX_PIXELS)) begin
         size_eff = SZ_W'(MAX_PIXELS);
      end
      idx_next = SZ_W'(pixel_index_ff) + SZ_W'(1);
      eof_cur  = (idx_next >= size_eff);
   end

   assign hazard = (s1_v_ff && !s1_rst_ff && (s1_idx_ff == pixel_index_ff)) ||
                   (s2_v_ff && !s2_rst_ff && (s2_idx_ff == pixel_index_ff)) ||
                   (s3_v_ff && !s3_rst_ff && (s3_idx_ff == pixel_index_ff)) ||
                   (s4_v_ff && !s4_rst_ff && (s4_idx_ff == pixel_index_ff));

   assign req_ready = (credit_ff < RQ_W'(RSP_DEPTH)) && !hazard;
   assign req_acc   = req_valid && req_ready;

   always_comb begin
      pixel_index_in = pixel_index_ff;
      frames_seen_in = frames_seen_ff;
      if (req_acc) begin
         if (req_cmd == CMD_RESTART) begin
            pixel_index_in = '0;
            frames_seen_in = SEEN_NONE;
         end else if (eof_cur) begin
            pixel_index_in = '0;
            if (frames_seen_ff != SEEN_FULL) begin
               frames_seen_in = seen_type'(frames_seen_ff + 2'd1);
            end
         end else begin
            pixel_index_in = pixel_index_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_index_ff <= '0;
         frames_seen_ff <= SEEN_NONE;
      end else begin
         pixel_index_ff <= pixel_index_in;
         frames_seen_ff <= frames_seen_in;
      end
   end

   // ---------------------------------------------------------- frame memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[s4_idx_ff] <= wr_word;
      end
      rd_word_ff <= frame_mem[pixel_index_ff];
   end

   // ---------------------------------------------------------------- stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= req_acc;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
   end

   // stage 1: compare against history, form the blend products
   always_comb begin
      s1_bg_old = (s1_mode_ff == SEEN_START) ? '0 : rd_word_ff.bg;
      s1_th_old = (s1_mode_ff == SEEN_START) ? START_THRESH : rd_word_ff.th;
      s1_mov    = (s1_mode_ff inside {SEEN_START, SEEN_FULL}) &&
                  (abs_diff(s1_pix_ff, rd_word_ff.prev) > s1_th_old) &&
                  (abs_diff(s1_pix_ff, rd_word_ff.older) > s1_th_old);
      s2_pa_bg_in  = MUL_W'(alpha_a) * MUL_W'(s1_bg_old);
      s2_pb_pix_in = MUL_W'(alpha_b) * MUL_W'(s1_pix_ff);
      s2_pa_th_in  = MUL_W'(alpha_a) * MUL_W'(s1_th_old);
   end

   // stage 2: round the background, take the spread
   always_comb begin
      s2_bg_sum    = s2_pa_bg_ff + s2_pb_pix_ff + BG_ROUND;
      s2_bg_q      = s2_bg_sum[MUL_W-1:BG_FRAC];
      s2_bg_blend  = (s2_bg_q > {1'b0, PIX_MAX}) ? PIX_MAX : s2_bg_q[PIX_W-1:0];
      s3_bg_new_in = s2_mov_ff ? s2_bg_old_ff : s2_bg_blend;
      s3_diff_in   = abs_diff(s2_pix_ff, s2_bg_blend);
   end

   // stage 3: scale the spread
   assign s4_prod_in = PROD_W'(gb_ff) * PROD_W'(s3_diff_ff);

   // stage 4: sum, round and saturate the threshold, write back
   always_comb begin
      s4_acc       = ACC_W'({s4_pa_th_ff, 8'b0}) + ACC_W'(s4_prod_ff);
      s4_rnd       = s4_acc + (ACC_W'(1) << (TH_FRAC - 1));
      s4_rnd_q     = s4_rnd[ACC_W-1:TH_FRAC];
      s4_th_blend  = (s4_rnd_q > (ACC_W-TH_FRAC)'(PIX_MAX)) ? PIX_MAX
                                                           : s4_rnd_q[PIX_W-1:0];
      s4_th_upd    = (s4_acc > (ACC_W'(MIN_THRESH) << TH_FRAC)) ? s4_th_blend
                                                                : s4_th_old_ff;
      s4_th_new    = s4_mov_ff ? MIN_THRESH : s4_th_upd;
      s4_processed = (s4_mode_ff inside {SEEN_START, SEEN_FULL});

      wr_en         = s4_v_ff && !s4_rst_ff;
      wr_word.prev  = s4_pix_ff;
      wr_word.older = s4_prev_ff;
      wr_word.bg    = s4_processed ? s4_bg_new_ff : s4_bg_old_ff;
      wr_word.th    = s4_processed ? s4_th_new : s4_th_old_ff;

      s4_item.valid_res      = s4_processed && !s4_rst_ff;
      s4_item.background_out = s4_item.valid_res ? s4_bg_new_ff : '0;
      s4_item.moving         = s4_item.valid_res && s4_mov_ff;
      s4_item.threshold_out  = s4_item.valid_res ? s4_th_new : '0;
      s4_item.end_of_frame   = !s4_rst_ff && s4_eof_ff;
   end

   always_ff @(posedge clock) begin
      s1_rst_ff  <= (req_cmd == CMD_RESTART);
      s1_eof_ff  <= eof_cur;
      s1_idx_ff  <= pixel_index_ff;
      s1_pix_ff  <= req_pixel;
      s1_mode_ff <= frames_seen_ff;

      s2_rst_ff    <= s1_rst_ff;
      s2_eof_ff    <= s1_eof_ff;
      s2_mov_ff    <= s1_mov;
      s2_idx_ff    <= s1_idx_ff;
      s2_pix_ff    <= s1_pix_ff;
      s2_prev_ff   <= rd_word_ff.prev;
      s2_bg_old_ff <= s1_bg_old;
      s2_th_old_ff <= s1_th_old;
      s2_mode_ff   <= s1_mode_ff;
      s2_pa_bg_ff  <= s2_pa_bg_in;
      s2_pb_pix_ff <= s2_pb_pix_in;
      s2_pa_th_ff  <= s2_pa_th_in;

      s3_rst_ff    <= s2_rst_ff;
      s3_eof_ff    <= s2_eof_ff;
      s3_mov_ff    <= s2_mov_ff;
      s3_idx_ff    <= s2_idx_ff;
      s3_pix_ff    <= s2_pix_ff;
      s3_prev_ff   <= s2_prev_ff;
      s3_bg_old_ff <= s2_bg_old_ff;
      s3_th_old_ff <= s2_th_old_ff;
      s3_bg_new_ff <= s3_bg_new_in;
      s3_diff_ff   <= s3_diff_in;
      s3_mode_ff   <= s2_mode_ff;
      s3_pa_th_ff  <= s2_pa_th_ff;

      s4_rst_ff    <= s3_rst_ff;
      s4_eof_ff    <= s3_eof_ff;
      s4_mov_ff    <= s3_mov_ff;
      s4_idx_ff    <= s3_idx_ff;
      s4_pix_ff    <= s3_pix_ff;
      s4_prev_ff   <= s3_prev_ff;
      s4_bg_old_ff <= s3_bg_old_ff;
      s4_th_old_ff <= s3_th_old_ff;
      s4_bg_new_ff <= s3_bg_new_ff;
      s4_mode_ff   <= s3_mode_ff;
      s4_pa_th_ff  <= s3_pa_th_ff;
      s4_prod_ff   <= s4_prod_in;
   end

   // ---------------------------------------------------------- result queue
   assign rsp_valid = (count_ff != '0);
   assign rsp_pop   = rsp_valid && rsp_ready;
   assign rsp_head  = rsp_fifo[rd_ptr_ff];

   assign rsp_valid_res      = rsp_head.valid_res;
   assign rsp_background_out = rsp_head.background_out;
   assign rsp_moving         = rsp_head.moving;
   assign rsp_threshold_out  = rsp_head.threshold_out;
   assign rsp_end_of_frame   = rsp_head.end_of_frame;

   always_comb begin
      count_in  = count_ff + RQ_W'(s4_v_ff) - RQ_W'(rsp_pop);
      credit_in = credit_ff + RQ_W'(req_acc) - RQ_W'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (s4_v_ff) begin
         rsp_fifo[wr_ptr_ff] <= s4_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         credit_ff <= '0;
      end else begin
         if (s4_v_ff) begin
            wr_ptr_ff <= wr_ptr_ff + RSP_PTR_W'(1);
         end
         if (rsp_pop) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_PTR_W'(1);
         end
         count_ff  <= count_in;
         credit_ff <= credit_in;
      end
   end

   // ------------------------------------------------------------ assertions
   a_no_queue_overflow: assert property (@(posedge clock) disable iff (reset)
      s4_v_ff |-> (count_ff < RQ_W'(RSP_DEPTH)))
      else $error("result queue overflow");

   a_credit_covers_queue: assert property (@(posedge clock) disable iff (reset)
      credit_ff >= count_ff)
      else $error("credit count below queue fill");

   a_no_overlap_read: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && !s1_rst_ff && s2_v_ff && !s2_rst_ff) |-> (s1_idx_ff != s2_idx_ff))
      else $error("two items on one pixel entry in flight");

   a_no_stale_read: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && !s1_rst_ff && s4_v_ff && !s4_rst_ff) |-> (s1_idx_ff != s4_idx_ff))
      else $error("read issued before write-back of the same entry");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(pixel_index_ff) < CNT_W'(MAX_PIXELS))
      else $error("pixel index beyond memory depth");

endmodule
`default_nettype wire
